[sv/ed_pkg.sv]
// ----------------------------------------------------------------------------
// ed_pkg
// Shared codes, types and constants of the edit distance engine.
// ----------------------------------------------------------------------------
package ed_pkg;

   localparam int CHAR_W = 16;
   localparam int THR_W  = 7;
   localparam int DIST_W = 7;

   typedef logic [CHAR_W-1:0] char_type;

   // request codes carried in req_tuser
   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_TEXT   = 2'd1;
   localparam logic [1:0] REQ_FINISH = 2'd2;

   localparam logic [THR_W-1:0]  THRESHOLD_RESET = 7'd5;
   localparam logic [DIST_W-1:0] DIST_SAT        = 7'd127;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic     clear;
      logic     load;
      char_type load_char;
   } cell_ctrl_type;

endpackage

[sv/edit_distance_engine.sv]
// A finish item gives its result in the cycle after it is accepted.
// Throughput: pattern and text items are taken one per cycle; each text item
// walks the row of MAX_LEN cells as a wavefront, one cell per cycle.
// A finish item waits until the last text item has left the row. Reset is
// synchronous, active high, and clears lengths, error flag and table row at
// once; threshold goes to 5.
// ----------------------------------------------------------------------------
// edit_distance_engine
// Levenshtein edit distance between a loaded pattern and a streamed text.
// ----------------------------------------------------------------------------
module edit_distance_engine
   import ed_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,   // char_code
   input  logic [1:0]        req_tuser,   // req_type
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // distance, zero pad
   output logic [1:0]        rsp_tuser,   // within_threshold, input_error
   input  logic              csr_wr_en,
   input  logic [THR_W-1:0]  csr_wr_data
);

   localparam int IW = $clog2(MAX_LEN + 1);
   localparam int VW = $clog2(MAX_LEN + 2);
   localparam int CNT_W = $clog2(MAX_LEN + 2);
   localparam int CW = (VW > DIST_W) ? VW : DIST_W;

   logic [THR_W-1:0]  thr_ff;
   logic [IW-1:0]     plen_ff, plen_in;
   logic [IW-1:0]     tlen_ff, tlen_in;
   logic              err_ff,  err_in;
   logic [CNT_W-1:0]  drain_ff, drain_in;
   logic [VW-1:0]     dist_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              rsp_within_ff, rsp_err_ff;

   logic              launch_ff, launch_in;
   char_type          lchar_ff;
   logic [VW-1:0]     lleft_ff, lleft_in;
   logic [VW-1:0]     ldiag_ff, ldiag_in;

   logic              accept, is_finish, fin_ok;
   logic              load_ok, text_ok;
   cell_ctrl_type     ctrl;
   logic [VW-1:0]     fin_dist;
   logic [CW-1:0]     fin_ext;

   logic              tok_valid [0:MAX_LEN];
   char_type          tok_char  [0:MAX_LEN];
   logic [VW-1:0]     tok_left  [0:MAX_LEN];
   logic [VW-1:0]     tok_diag  [0:MAX_LEN];

   assign is_finish = (req_tuser == REQ_FINISH);
   // finish only once the row is quiet and the result slot is free
   assign fin_ok    = (drain_ff == '0) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !is_finish || fin_ok;
   assign accept    = req_tvalid && req_tready;

   assign load_ok = (tlen_ff == '0) && (plen_ff != IW'(MAX_LEN));
   assign text_ok = (tlen_ff != IW'(MAX_LEN));

   assign fin_dist = (tlen_ff == '0) ? VW'(plen_ff) : dist_ff;
   assign fin_ext  = CW'(fin_dist);

   always_comb begin
      plen_in      = plen_ff;
      tlen_in      = tlen_ff;
      err_in       = err_ff;
      launch_in    = 1'b0;
      lleft_in     = VW'(tlen_ff) + VW'(1);
      ldiag_in     = VW'(tlen_ff);
      drain_in     = (drain_ff != '0) ? drain_ff - CNT_W'(1) : drain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ctrl.clear     = 1'b0;
      ctrl.load      = 1'b0;
      ctrl.load_char = req_tdata;
      if (accept) begin
         case (req_tuser)
            REQ_LOAD: begin
               if (load_ok) begin
                  ctrl.load = 1'b1;
                  plen_in   = plen_ff + IW'(1);
               end else begin
                  err_in = 1'b1;
               end
            end
            REQ_TEXT: begin
               if (text_ok) begin
                  launch_in = 1'b1;
                  tlen_in   = tlen_ff + IW'(1);
                  drain_in  = CNT_W'(MAX_LEN + 1);
               end else begin
                  err_in = 1'b1;
               end
            end
            REQ_FINISH: begin
               rsp_valid_in = 1'b1;
               ctrl.clear   = 1'b1;
               plen_in      = '0;
               tlen_in      = '0;
               err_in       = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THRESHOLD_RESET;
         plen_ff      <= '0;
         tlen_ff      <= '0;
         err_ff       <= 1'b0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         launch_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         plen_ff      <= plen_in;
         tlen_ff      <= tlen_in;
         err_ff       <= err_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
         launch_ff    <= launch_in;
      end
   end

   always_ff @(posedge clock) begin
      lchar_ff <= req_tdata;
      lleft_ff <= lleft_in;
      ldiag_ff <= ldiag_in;
      // the token leaving the last cell carries the last loaded entry
      if (tok_valid[MAX_LEN]) begin
         dist_ff <= tok_left[MAX_LEN];
      end
      if (accept && is_finish) begin
         rsp_dist_ff   <= (fin_ext > CW'(DIST_SAT)) ? DIST_SAT : fin_ext[DIST_W-1:0];
         rsp_within_ff <= (fin_ext <= CW'(thr_ff));
         rsp_err_ff    <= err_ff;
      end
   end

   assign tok_valid[0] = launch_ff;
   assign tok_char[0]  = lchar_ff;
   assign tok_left[0]  = lleft_ff;
   assign tok_diag[0]  = ldiag_ff;

   for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
      ed_cell #(
         .VW (VW),
         .IW (IW),
         .J  (j)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .load_idx  (plen_ff),
         .in_valid  (tok_valid[j-1]),
         .in_char   (tok_char[j-1]),
         .in_left   (tok_left[j-1]),
         .in_diag   (tok_diag[j-1]),
         .out_valid (tok_valid[j]),
         .out_char  (tok_char[j]),
         .out_left  (tok_left[j]),
         .out_diag  (tok_diag[j])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_dist_ff};
   assign rsp_tuser  = {rsp_err_ff, rsp_within_ff};

   // no result is produced while a text token is still in the row
   a_fin_drained: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && is_finish) |-> (drain_ff == '0))
      else $error("finish taken with tokens in flight");

   // a finish leaves both lengths and the error flag cleared
   a_fin_clears: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && is_finish) |=>
      (plen_ff == '0 && tlen_ff == '0 && !err_ff))
      else $error("finish did not restart the engine");

   // lengths never pass the row size
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (plen_ff <= IW'(MAX_LEN)) && (tlen_ff <= IW'(MAX_LEN)))
      else $error("length out of range");

   // a result appears only in the cycle after a finish was taken
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_tvalid && req_tready && is_finish))
      else $error("result without finish");

endmodule

[sv/ed_cell.sv]
// ----------------------------------------------------------------------------
// ed_cell
// One pattern position: holds its pattern character and table entry, updates
// the entry as a text token passes and hands the token to the next cell.
// ----------------------------------------------------------------------------
module ed_cell
   import ed_pkg::*;
#(
   parameter int VW = 7,
   parameter int IW = 7,
   parameter int J  = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic [IW-1:0] load_idx,
   input  logic          in_valid,
   input  char_type      in_char,
   input  logic [VW-1:0] in_left,
   input  logic [VW-1:0] in_diag,
   output logic          out_valid,
   output char_type      out_char,
   output logic [VW-1:0] out_left,
   output logic [VW-1:0] out_diag
);

   char_type      pchar_ff;
   logic          loaded_ff;
   logic [VW-1:0] row_ff,   row_in;
   logic          valid_ff;
   char_type      char_ff;
   logic [VW-1:0] left_ff,  left_in;
   logic [VW-1:0] diag_ff,  diag_in;
   logic [VW-1:0] cand_up, cand_left, cand_diag, min_ul, cell_val;

   always_comb begin
      cand_up   = row_ff + VW'(1);
      cand_left = in_left + VW'(1);
      cand_diag = in_diag + VW'(pchar_ff != in_char);
      min_ul    = (cand_up < cand_left) ? cand_up : cand_left;
      cell_val  = (min_ul < cand_diag) ? min_ul : cand_diag;
      row_in    = row_ff;
      left_in   = in_left;
      diag_in   = in_diag;
      // cells past the pattern end pass the token on untouched
      if (in_valid && loaded_ff) begin
         row_in  = cell_val;
         left_in = cell_val;
         diag_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         row_ff    <= VW'(J);
         loaded_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         row_ff   <= row_in;
         valid_ff <= in_valid;
         if (ctrl.load && load_idx == IW'(J - 1)) begin
            loaded_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load && load_idx == IW'(J - 1)) begin
         pchar_ff <= ctrl.load_char;
      end
      char_ff <= in_char;
      left_ff <= left_in;
      diag_ff <= diag_in;
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_left  = left_ff;
   assign out_diag  = diag_ff;

endmodule
